[hw/rtl/dfr_pkg.sv]
// Package for the DNS fixed A reply builder.
// Holds the widths, packet constants, register indexes and the job type that
// pass between the parser and the reply emitter. Depends on nothing.
`default_nettype none

package dfr_pkg;

  localparam int POS_W       = 11;
  localparam int MAX_PACKET  = 512;
  localparam int HEADER_LEN  = 12;
  localparam int QUESTION_TAIL = 5;
  localparam int ANSWER_LEN  = 16;
  localparam int ANSWER_HEAD_LEN = 12;
  localparam int ANS_IDX_W   = $clog2(ANSWER_LEN);
  localparam int CAP_W       = 11;
  localparam int ADDR_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ADDRESS = 1'd1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd512;

  localparam logic [7:0] FLAGS_HI = 8'h81;
  localparam logic [7:0] FLAGS_LO = 8'h80;
  localparam logic [7:0] PTR_HI   = 8'hC0;
  localparam logic [7:0] PTR_LO   = 8'h0C;
  localparam logic [7:0] TTL_LO   = 8'h3C;

  localparam logic [7:0] ANSWER_HEAD [ANSWER_HEAD_LEN] = '{
    PTR_HI, PTR_LO, 8'h00, 8'h01, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h00, TTL_LO, 8'h00, 8'h04
  };

  typedef struct packed {
    logic       pass;
    logic       answer;
    logic       error;
    logic [7:0] data;
  } job_t;

  function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                             input logic [ADDR_W-1:0] addr);
    logic [7:0] b;
    if (idx < ANS_IDX_W'(ANSWER_HEAD_LEN)) begin
      b = ANSWER_HEAD[idx];
    end else begin
      unique case (idx[1:0])
        2'd0: b = addr[31:24];
        2'd1: b = addr[23:16];
        2'd2: b = addr[15:8];
        2'd3: b = addr[7:0];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dfr_query_if.sv]
// Channel interface for query bytes entering the reply builder.
// Carries valid, ready and the query payload. Depends on nothing.
`default_nettype none

interface dfr_query_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_byte;
  logic       query_last;

  modport source (output valid, output query_byte, output query_last, input ready);
  modport sink   (input valid, input query_byte, input query_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/dfr_reply_if.sv]
// Channel interface for reply bytes leaving the reply builder.
// Carries valid, ready and the reply payload. Depends on nothing.
`default_nettype none

interface dfr_reply_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_last;
  logic       reply_error;

  modport source (output valid, output reply_byte, output reply_last,
                  output reply_error, input ready);
  modport sink   (input valid, input reply_byte, input reply_last,
                  input reply_error, output ready);
endinterface

`default_nettype wire

[hw/rtl/dfr_parse.sv]
// Query parser: follows header offsets and QNAME labels, decides per byte.
// Produces one job per accepted byte for the emitter. Depends on dfr_pkg.
`default_nettype none

module dfr_parse (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         accept,
  input  wire  [7:0]                  query_byte,
  input  wire                         query_last,
  input  wire  [dfr_pkg::CAP_W-1:0]   reply_capacity,
  output dfr_pkg::job_t               job
);
  import dfr_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] next_label_position;
  logic [POS_W-1:0] question_end;
  logic             end_found;
  logic             overlong;

  logic [POS_W-1:0] next_label_position_next;
  logic [POS_W-1:0] question_end_next;
  logic             end_found_next;
  logic             in_range;
  logic             hit;
  logic             keep;
  logic             bad;
  logic [7:0]       out_byte;
  logic [POS_W:0]   len;
  logic [POS_W:0]   room_needed;

  always_comb begin
    in_range = byte_position < POS_W'(MAX_PACKET);
    unique case (byte_position)
      11'd2:   out_byte = FLAGS_HI;
      11'd3:   out_byte = FLAGS_LO;
      11'd7:   out_byte = 8'h01;
      11'd6, 11'd8, 11'd9, 11'd10, 11'd11: out_byte = 8'h00;
      default: out_byte = query_byte;
    endcase
    hit = in_range && !end_found && (byte_position == next_label_position);
    end_found_next = end_found;
    question_end_next = question_end;
    next_label_position_next = next_label_position;
    if (hit) begin
      if (query_byte == 8'h00) begin
        end_found_next = 1'b1;
        question_end_next = byte_position + POS_W'(QUESTION_TAIL);
      end else begin
        next_label_position_next = next_label_position + POS_W'(query_byte)
                                   + POS_W'(1);
      end
    end
    keep = in_range && (!end_found_next || byte_position < question_end_next);
    len = {1'b0, byte_position} + (POS_W+1)'(1);
    room_needed = {1'b0, question_end_next} + (POS_W+1)'(ANSWER_LEN);
    bad = !in_range || overlong || len < (POS_W+1)'(HEADER_LEN) || !end_found_next
          || {1'b0, question_end_next} > len
          || room_needed > {1'b0, reply_capacity};
    job.pass   = keep && !(query_last && bad);
    job.answer = query_last && !bad;
    job.error  = query_last && bad;
    job.data   = out_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      next_label_position <= POS_W'(HEADER_LEN);
      question_end <= '0;
      end_found <= 1'b0;
      overlong <= 1'b0;
    end else if (accept) begin
      if (query_last) begin
        byte_position <= '0;
        next_label_position <= POS_W'(HEADER_LEN);
        question_end <= '0;
        end_found <= 1'b0;
        overlong <= 1'b0;
      end else if (in_range) begin
        byte_position <= byte_position + POS_W'(1);
        next_label_position <= next_label_position_next;
        question_end <= question_end_next;
        end_found <= end_found_next;
      end else begin
        overlong <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dfr_emit.sv]
// Reply emitter: output register and the answer sequencer.
// Turns parser jobs into reply results, appending the A answer. Depends on dfr_pkg.
`default_nettype none

module dfr_emit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          job_valid,
  input  wire  dfr_pkg::job_t          job,
  output logic                         job_ready,
  input  wire  [dfr_pkg::ADDR_W-1:0]   answer_address,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  output logic                         out_error
);
  import dfr_pkg::*;

  logic                 busy;
  logic [ANS_IDX_W-1:0] idx;
  logic                 slot_free;

  assign slot_free = !out_valid || out_ready;
  assign job_ready = slot_free && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy <= 1'b0;
      idx <= '0;
    end else if (slot_free) begin
      if (busy) begin
        out_valid <= 1'b1;
        idx <= idx + ANS_IDX_W'(1);
        if (idx == ANS_IDX_W'(ANSWER_LEN - 1)) begin
          busy <= 1'b0;
        end
      end else if (job_valid) begin
        out_valid <= job.error || job.pass || job.answer;
        if (!job.error && job.answer) begin
          busy <= 1'b1;
          idx <= job.pass ? ANS_IDX_W'(0) : ANS_IDX_W'(1);
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (busy) begin
        out_byte <= answer_byte(idx, answer_address);
        out_last <= idx == ANS_IDX_W'(ANSWER_LEN - 1);
        out_error <= 1'b0;
      end else if (job_valid) begin
        if (job.error) begin
          out_byte <= 8'h00;
          out_last <= 1'b1;
          out_error <= 1'b1;
        end else if (job.pass) begin
          out_byte <= job.data;
          out_last <= 1'b0;
          out_error <= 1'b0;
        end else begin
          out_byte <= answer_byte(ANS_IDX_W'(0), answer_address);
          out_last <= 1'b0;
          out_error <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTH
  a_busy_has_output: assert property (@(posedge clk) disable iff (rst)
    busy |-> out_valid)
    else $error("answer sequencer busy without a pending result");

  a_answer_ends_last: assert property (@(posedge clk) disable iff (rst)
    (busy && slot_free && idx == ANS_IDX_W'(ANSWER_LEN - 1)) |=> (out_valid && out_last))
    else $error("final answer byte not marked last");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job_ready && job.error) |=> (out_valid && out_error && out_last))
    else $error("error job did not give a final error result");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_error) |-> (out_byte == 8'h00 && !busy))
    else $error("error result carries data or an answer follows it");
`endif

endmodule

`default_nettype wire

[hw/rtl/dns_fixed_a_reply_builder.sv]
// Top level of the DNS fixed A reply builder.
// Holds the configuration registers and joins the parser and the emitter.
// Depends on dfr_pkg, dfr_query_if, dfr_reply_if, dfr_parse and dfr_emit.
//
// Usage: query bytes arrive on the query channel, one request per byte, with
// query_last on the final byte of a packet. Each kept byte appears on the
// reply channel in the cycle after it is accepted, with the DNS header flags and
// counts rewritten; bytes past the question are dropped. At the final byte
// the block either gives a single error result or appends the 16-byte A
// answer, the last of which carries reply_last.
// Throughput: one query byte per cycle while the receiver takes results and no
// answer is being sent. The final byte of a good packet gives 16 or 17 results,
// set by the answer sequencer, and the query channel is held off until the last
// answer byte has entered the output register.
// Reset clears the parse state and the output register; reply_capacity
// returns to 512 and answer_address to zero. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while the block is idle, the block does not enforce it.
// When the receiver stalls, the pending result holds in the output register
// and no further query byte is taken until it leaves.
`default_nettype none

module dns_fixed_a_reply_builder (
  input  wire                                clk,
  input  wire                                rst,
  dfr_query_if.sink                          query,
  dfr_reply_if.source                        reply,
  input  wire                                cfg_we,
  input  wire  [dfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [dfr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dfr_pkg::*;

  logic [CAP_W-1:0]  reply_capacity;
  logic [ADDR_W-1:0] answer_address;
  logic              accept;
  logic              job_ready;
  job_t              job;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_capacity <= CAPACITY_RESET;
      answer_address <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLY_CAPACITY: reply_capacity <= cfg_data[CAP_W-1:0];
        CFG_ANSWER_ADDRESS: answer_address <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign query.ready = job_ready;
  assign accept = query.valid && job_ready;

  dfr_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .query_byte     (query.query_byte),
    .query_last     (query.query_last),
    .reply_capacity (reply_capacity),
    .job            (job)
  );

  dfr_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (accept),
    .job            (job),
    .job_ready      (job_ready),
    .answer_address (answer_address),
    .out_valid      (reply.valid),
    .out_ready      (reply.ready),
    .out_byte       (reply.reply_byte),
    .out_last       (reply.reply_last),
    .out_error      (reply.reply_error)
  );

endmodule

`default_nettype wire
